// ===== src/afe_pkg.sv =====
// Shared types and constants for the audio fade and echo effect core.
`timescale 1ns / 1ps

package afe_pkg;

  localparam int IDX_W = 35;
  localparam int RATE_W = 17;
  localparam int CHAN_W = 4;
  localparam int FRAMES_W = 32;
  localparam int GAIN_W = 24;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SPAN_W = 21;
  localparam int FADE_W = 23;
  localparam int TOTAL_W = 36;
  localparam int STEP_W = $clog2(IDX_W + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(1);

  typedef enum logic [1:0] {
    MODE_FADE_IN  = 2'd0,
    MODE_FADE_OUT = 2'd1,
    MODE_INVERT   = 2'd2,
    MODE_ECHO     = 2'd3
  } effect_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 2'd0,
    REG_RATE     = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_FRAMES   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/afe_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module afe_div #(
  parameter int VW = 23
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [afe_pkg::IDX_W-1:0]   dividend,
  input  logic [VW-1:0]               init_rem,
  input  logic [VW-1:0]               divisor,
  input  logic [afe_pkg::STEP_W-1:0]  steps,
  output afe_pkg::div_stat_t          stat,
  output logic [afe_pkg::IDX_W-1:0]   quotient,
  output logic [VW-1:0]               remainder
);

  logic [afe_pkg::IDX_W-1:0]  dvd;
  logic [afe_pkg::STEP_W-1:0] cnt;
  logic [VW-1:0]              div_r;
  logic [VW:0]                trial;
  logic                       fits;

  // The partial remainder stays below the divisor, so one extra bit holds the shifted value.
  assign trial = {remainder, dvd[afe_pkg::IDX_W-1]};
  assign fits = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt <= '0;
    end else begin
      // Done pulses for one cycle after the last step.
      stat.done <= !start && stat.busy && (cnt == afe_pkg::STEP_W'(1));
      if (start) begin
        remainder <= init_rem;
        dvd <= dividend;
        div_r <= divisor;
        quotient <= '0;
        cnt <= steps;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        remainder <= fits ? VW'(trial - {1'b0, div_r}) : VW'(trial);
        dvd <= {dvd[afe_pkg::IDX_W-2:0], 1'b0};
        quotient <= {quotient[afe_pkg::IDX_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == afe_pkg::STEP_W'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/audio_fade_echo_effect_core.sv =====
// Top level of the audio fade, invert and echo effect with its delay memory.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: sample_in; tuser: start_of_stream
//   m_axis    out        tdata: sample_out
//   cfg       in         write enable, register index, write data
//
// Invert, pass-through and zeroed samples go from PREP and DECIDE straight to
// DONE; a fade out at full gain adds the MUL and SCALE states, any other fade
// first runs 24 divider steps for the gain, and echo runs 35 divider steps to find
// the delay address, then one memory read and one write.
// The serial divider takes the longest; the input waits only for the previous sample.
// A finished result sits in the output register, so a new sample is accepted
// while it waits; the next result waits there only if it is still not taken.
// Reset is synchronous; the delay memory is not cleared.
`timescale 1ns / 1ps

module audio_fade_echo_effect_core #(
  parameter int DELAY_DEPTH = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // sample_in
  input  logic [0:0]                           s_axis_tuser,   // start_of_stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,   // sample_out
  input  logic                                 cfg_wen,
  input  logic [afe_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [afe_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int LW = $clog2(DELAY_DEPTH + 1);
  localparam int VW = (afe_pkg::FADE_W > LW) ? afe_pkg::FADE_W : LW;
  localparam int CW = (afe_pkg::SPAN_W > LW) ? afe_pkg::SPAN_W : LW;
  localparam int PW = SB + afe_pkg::GAIN_W + 1;
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DECIDE, S_DIV, S_READ, S_ECHO, S_MUL, S_SCALE, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  afe_pkg::effect_mode_t              mode_r;
  logic [afe_pkg::RATE_W-1:0]         rate_r;
  logic [afe_pkg::CHAN_W-1:0]         chan_r;
  logic [afe_pkg::FRAMES_W-1:0]       frames_r;

  logic [afe_pkg::IDX_W-1:0]          sample_index;
  logic [afe_pkg::IDX_W-1:0]          idx_r;
  logic [afe_pkg::IDX_W-1:0]          idx_start;
  logic signed [SB-1:0]               x_r;
  logic signed [SB-1:0]               y_r;
  logic [afe_pkg::FADE_W-1:0]         fade_r;
  logic [afe_pkg::TOTAL_W-1:0]        total_r;
  logic [LW-1:0]                      len_r;
  logic [afe_pkg::GAIN_W-1:0]         gain_r;
  logic signed [PW-1:0]               prod_r;
  logic [AW-1:0]                      addr_r;

  logic [afe_pkg::SPAN_W-1:0]         span_w;
  logic [afe_pkg::FADE_W-1:0]         fade_w;
  logic [afe_pkg::TOTAL_W-1:0]        total_w;
  logic [LW-1:0]                      len_w;

  logic                               fade_on;
  logic                               fi_active;
  logic                               fo_window;
  logic                               fo_past;
  logic [afe_pkg::TOTAL_W-1:0]        fo_num;
  logic                               fo_full;
  logic                               echo_on;
  logic signed [SB-1:0]               neg_x;
  logic signed [SB-1:0]               past_half;
  logic signed [SB:0]                 echo_sum;
  logic signed [SB-1:0]               echo_y;

  logic                               in_xfer;
  logic                               load_out;
  logic                               mem_we;

  logic                               div_start;
  logic [afe_pkg::IDX_W-1:0]          div_dividend;
  logic [VW-1:0]                      div_init;
  logic [VW-1:0]                      div_divisor;
  logic [afe_pkg::STEP_W-1:0]         div_steps;
  afe_pkg::div_stat_t                 div_stat;
  logic [afe_pkg::IDX_W-1:0]          div_quot;
  logic [VW-1:0]                      div_rem;

  logic signed [SB-1:0]               delay_mem [DELAY_DEPTH];
  logic signed [SB-1:0]               rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= afe_pkg::MODE_FADE_IN;
      rate_r <= afe_pkg::RATE_RESET;
      chan_r <= afe_pkg::CHAN_RESET;
      frames_r <= '0;
    end else if (cfg_wen) begin
      case (afe_pkg::cfg_reg_t'(cfg_addr))
        afe_pkg::REG_MODE:     mode_r <= afe_pkg::effect_mode_t'(cfg_wdata[1:0]);
        afe_pkg::REG_RATE:     rate_r <= cfg_wdata[afe_pkg::RATE_W-1:0];
        afe_pkg::REG_CHANNELS: chan_r <= cfg_wdata[afe_pkg::CHAN_W-1:0];
        afe_pkg::REG_FRAMES:   frames_r <= cfg_wdata[afe_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths derived from the configuration, registered once per sample.
  assign span_w = afe_pkg::SPAN_W'(rate_r) * afe_pkg::SPAN_W'(chan_r);
  assign fade_w = (afe_pkg::FADE_W'(span_w) << 1) + afe_pkg::FADE_W'(span_w);
  assign total_w = afe_pkg::TOTAL_W'(frames_r) * afe_pkg::TOTAL_W'(chan_r);
  assign len_w = (CW'(span_w) > CW'(DELAY_DEPTH)) ? LW'(DELAY_DEPTH) : LW'(span_w);

  assign fade_on = fade_r != '0;
  assign fi_active = fade_on && (idx_r < afe_pkg::IDX_W'(fade_r));
  assign fo_window = fade_on && ((afe_pkg::TOTAL_W'(idx_r) + afe_pkg::TOTAL_W'(fade_r))
                                 >= total_r);
  assign fo_past = afe_pkg::TOTAL_W'(idx_r) >= total_r;
  assign fo_num = total_r - afe_pkg::TOTAL_W'(idx_r);
  // A gain of exactly one does not fit the fraction and saturates.
  assign fo_full = fo_num >= afe_pkg::TOTAL_W'(fade_r);
  assign echo_on = len_r != '0;

  assign neg_x = (x_r == SMIN) ? SMAX : -x_r;
  assign past_half = rdata >>> 1;
  assign echo_sum = {x_r[SB-1], x_r} + {past_half[SB-1], past_half};
  always_comb begin
    if (echo_sum[SB] != echo_sum[SB-1]) begin
      echo_y = echo_sum[SB] ? SMIN : SMAX;
    end else begin
      echo_y = echo_sum[SB-1:0];
    end
  end

  assign s_axis_tready = state == S_IDLE;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign idx_start = s_axis_tuser[0] ? '0 : sample_index;
  assign load_out = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign mem_we = state == S_ECHO;

  always_comb begin
    div_start = 1'b0;
    div_dividend = '0;
    div_init = '0;
    div_divisor = VW'(fade_r);
    div_steps = afe_pkg::STEP_W'(afe_pkg::GAIN_W);
    if (state == S_DECIDE) begin
      case (mode_r)
        afe_pkg::MODE_FADE_IN: begin
          div_start = fi_active;
          div_init = VW'(idx_r);
        end
        afe_pkg::MODE_FADE_OUT: begin
          div_start = fo_window && !fo_past && !fo_full;
          div_init = VW'(fo_num);
        end
        afe_pkg::MODE_ECHO: begin
          div_start = echo_on;
          div_dividend = idx_r;
          div_divisor = VW'(len_r);
          div_steps = afe_pkg::STEP_W'(afe_pkg::IDX_W);
        end
        default: ;
      endcase
    end
  end

  afe_div #(
    .VW(VW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .init_rem  (div_init),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Delay line: the old entry is read before the same entry takes the new sample.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rdata <= delay_mem[addr_r];
    end
    if (mem_we) begin
      delay_mem[addr_r] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sample_index <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A new result enters the output register only once the old one is taken.
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= TW'($unsigned(y_r));
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            x_r <= s_axis_tdata[SB-1:0];
            idx_r <= idx_start;
            sample_index <= idx_start + 1'b1;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          fade_r <= fade_w;
          total_r <= total_w;
          len_r <= len_w;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          case (mode_r)
            afe_pkg::MODE_FADE_IN: begin
              if (fi_active) begin
                state <= S_DIV;
              end else begin
                y_r <= x_r;
                state <= S_DONE;
              end
            end
            afe_pkg::MODE_FADE_OUT: begin
              if (!fo_window) begin
                y_r <= x_r;
                state <= S_DONE;
              end else if (fo_past) begin
                y_r <= '0;
                state <= S_DONE;
              end else if (fo_full) begin
                gain_r <= '1;
                state <= S_MUL;
              end else begin
                state <= S_DIV;
              end
            end
            afe_pkg::MODE_INVERT: begin
              y_r <= neg_x;
              state <= S_DONE;
            end
            afe_pkg::MODE_ECHO: begin
              if (echo_on) begin
                state <= S_DIV;
              end else begin
                y_r <= x_r;
                state <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (mode_r == afe_pkg::MODE_ECHO) begin
              addr_r <= div_rem[AW-1:0];
              state <= S_READ;
            end else begin
              gain_r <= div_quot[afe_pkg::GAIN_W-1:0];
              state <= S_MUL;
            end
          end
        end
        S_READ: begin
          state <= S_ECHO;
        end
        S_ECHO: begin
          // Until one full delay has gone by the sample passes through.
          y_r <= (idx_r >= afe_pkg::IDX_W'(len_r)) ? echo_y : x_r;
          state <= S_DONE;
        end
        S_MUL: begin
          prod_r <= x_r * $signed({1'b0, gain_r});
          state <= S_SCALE;
        end
        S_SCALE: begin
          // The arithmetic shift rounds toward minus infinity.
          y_r <= prod_r[afe_pkg::GAIN_W+SB-1:afe_pkg::GAIN_W];
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_mem_we_echo: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mode_r == afe_pkg::MODE_ECHO) && (len_r != '0))
    else $error("delay memory written outside echo mode");

  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (LW'(addr_r) < len_r))
    else $error("delay address not below the delay length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> sample_index == afe_pkg::IDX_W'(idx_r + 1'b1))
    else $error("sample index did not advance by one");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule
